// File: rtl/pps_pkg.sv
// Shared constants, types and the arctangent table of the pure-pursuit steering unit.
package pps_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int DIV_STEPS    = 32;

  // Angles inside the rotator are Q2.30 radians.
  localparam logic signed [33:0] ANG_PI      = 34'sd3373259426;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [7:0] {
    CFG_SPEED_REF = 8'd0,
    CFG_NEAR_THR  = 8'd1
  } cfg_reg_t;

  // Data that rides alongside the rotator.
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [65:0]        dsq;
    logic               active;
    logic               flip;
    logic               last;
  } side_t;

  // Flags that ride alongside the divider.
  typedef struct packed {
    logic active;
    logic neg;
    logic ovf;
    logic last;
  } div_tag_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:    a = 32'h3243F6A8;
      5'd1:    a = 32'h1DAC6705;
      5'd2:    a = 32'h0FADBAFC;
      5'd3:    a = 32'h07F56EA6;
      5'd4:    a = 32'h03FEAB76;
      5'd5:    a = 32'h01FFD55B;
      5'd6:    a = 32'h00FFFAAA;
      5'd7:    a = 32'h007FFF55;
      5'd8:    a = 32'h003FFFEA;
      5'd9:    a = 32'h001FFFFD;
      5'd10:   a = 32'h000FFFFF;
      5'd11:   a = 32'h0007FFFF;
      5'd12:   a = 32'h0003FFFF;
      5'd13:   a = 32'h0001FFFF;
      5'd14:   a = 32'h0000FFFF;
      5'd15:   a = 32'h00007FFF;
      5'd16:   a = 32'h00003FFF;
      5'd17:   a = 32'h00001FFF;
      5'd18:   a = 32'h00000FFF;
      5'd19:   a = 32'h000007FF;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/pure_pursuit_steering_unit.sv
// Pure-pursuit steering unit: pipelined distance test, sine/cosine rotator and divider.
//
//  channel | direction | beat contents
//  in_     | slave     | tdata {goal_y, goal_x, heading, agent_y, agent_x}, tlast last_agent
//  out_    | master    | tdata {0, turn_rate_cmd, speed_cmd}, tuser {rate_saturated,
//          |           | steer_active}, tlast last_agent_out
//  cfg_    | slave     | cfg_index register number, cfg_data value, always ready
//
// One vehicle enters per cycle unless the pipeline halts; each result passes through the
// 20-stage rotator and the 32-stage restoring divider.
// A synchronous active-low reset empties the pipeline and loads the register defaults.
// The pipeline moves as one; a two-entry output buffer lets it run on while one result
// waits, and it halts only when both entries are full.
module pure_pursuit_steering_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // agent_x, agent_y, heading, goal_x, goal_y
  input  logic         in_tlast,   // last_agent
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // speed_cmd, turn_rate_cmd, zero pad
  output logic [1:0]   out_tuser,  // steer_active, rate_saturated
  output logic         out_tlast,  // last_agent_out
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int NC = pps_pkg::CORDIC_STEPS;
  localparam int ND = pps_pkg::DIV_STEPS;

  logic en;

  // Configuration registers.
  logic [30:0] speed_ref_r, near_thr_r;
  logic [61:0] thr_sq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_ref_r <= 31'd65536;
      near_thr_r  <= 31'd6554;
    end else if (cfg_valid) begin
      if (cfg_index == pps_pkg::CFG_SPEED_REF) speed_ref_r <= cfg_data[30:0];
      if (cfg_index == pps_pkg::CFG_NEAR_THR)  near_thr_r  <= cfg_data[30:0];
    end
  end

  always_ff @(posedge clk) begin
    thr_sq_r <= near_thr_r * near_thr_r;
  end

  // Stage 0: differences and the heading as a Q3.30 angle.
  logic               s0_v_r, s0_last_r;
  logic signed [32:0] s0_dx_r, s0_dy_r, s0_z_r;
  logic signed [31:0] ax, ay, gx, gy;
  logic signed [15:0] hd;

  assign ax = in_tdata[31:0];
  assign ay = in_tdata[63:32];
  assign hd = in_tdata[79:64];
  assign gx = in_tdata[111:80];
  assign gy = in_tdata[143:112];

  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (en) s0_v_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_dx_r   <= {gx[31], gx} - {ax[31], ax};
      s0_dy_r   <= {gy[31], gy} - {ay[31], ay};
      s0_z_r    <= {hd, 17'd0};
      s0_last_r <= in_tlast;
    end
  end

  // Stage 1: magnitudes and folding the angle into the right half plane.
  logic               s1_v_r, s1_flip_r, s1_last_r;
  logic [32:0]        s1_adx_r, s1_ady_r;
  logic signed [32:0] s1_dx_r, s1_dy_r;
  logic signed [31:0] s1_z_r;
  logic signed [33:0] z_wide, z_fold;
  logic               flip_nxt;

  always_comb begin
    z_wide   = {s0_z_r[32], s0_z_r};
    z_fold   = z_wide;
    flip_nxt = 1'b0;
    priority if (z_wide > pps_pkg::ANG_HALF_PI) begin
      z_fold   = z_wide - pps_pkg::ANG_PI;
      flip_nxt = 1'b1;
    end else if (z_wide < -pps_pkg::ANG_HALF_PI) begin
      z_fold   = z_wide + pps_pkg::ANG_PI;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= s0_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_adx_r  <= s0_dx_r[32] ? 33'(-s0_dx_r) : 33'(s0_dx_r);
      s1_ady_r  <= s0_dy_r[32] ? 33'(-s0_dy_r) : 33'(s0_dy_r);
      s1_dx_r   <= s0_dx_r;
      s1_dy_r   <= s0_dy_r;
      s1_z_r    <= z_fold[31:0];
      s1_flip_r <= flip_nxt;
      s1_last_r <= s0_last_r;
    end
  end

  // Stage 2: squares.
  logic               s2_v_r, s2_flip_r, s2_last_r;
  logic [65:0]        s2_sqx_r, s2_sqy_r;
  logic signed [32:0] s2_dx_r, s2_dy_r;
  logic signed [31:0] s2_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sqx_r  <= s1_adx_r * s1_adx_r;
      s2_sqy_r  <= s1_ady_r * s1_ady_r;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_z_r    <= s1_z_r;
      s2_flip_r <= s1_flip_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Rotator: entry 0 is loaded from stage 2, each further entry is one micro-rotation.
  logic               cv_r [0:NC];
  logic signed [33:0] cx_r [0:NC];
  logic signed [33:0] cy_r [0:NC];
  logic signed [31:0] cz_r [0:NC];
  pps_pkg::side_t     cs_r [0:NC];

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else if (en) cv_r[0] <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]        <= pps_pkg::CORDIC_GAIN;
      cy_r[0]        <= '0;
      cz_r[0]        <= s2_z_r;
      cs_r[0].dx     <= s2_dx_r;
      cs_r[0].dy     <= s2_dy_r;
      cs_r[0].dsq    <= s2_sqx_r + s2_sqy_r;
      cs_r[0].active <= 1'b0;
      cs_r[0].flip   <= s2_flip_r;
      cs_r[0].last   <= s2_last_r;
    end
  end

  for (genvar j = 0; j < NC; j++) begin : g_rot
    logic signed [31:0] ang;
    pps_pkg::side_t     side_nxt;
    assign ang = pps_pkg::atan_q30(5'(j));

    // The distance test sits in the first rotation stage, after the sum is registered.
    always_comb begin
      side_nxt = cs_r[j];
      if (j == 0) side_nxt.active = cs_r[j].dsq > {4'd0, thr_sq_r};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[j+1] <= 1'b0;
      else if (en) cv_r[j+1] <= cv_r[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz_r[j][31]) begin
          cx_r[j+1] <= cx_r[j] - (cy_r[j] >>> j);
          cy_r[j+1] <= cy_r[j] + (cx_r[j] >>> j);
          cz_r[j+1] <= cz_r[j] - ang;
        end else begin
          cx_r[j+1] <= cx_r[j] + (cy_r[j] >>> j);
          cy_r[j+1] <= cy_r[j] - (cx_r[j] >>> j);
          cz_r[j+1] <= cz_r[j] + ang;
        end
        cs_r[j+1] <= side_nxt;
      end
    end
  end

  // Stage sc: undo the fold and scale to Q4.28.
  logic               sc_v_r;
  logic signed [31:0] sc_c_r, sc_s_r;
  pps_pkg::side_t     sc_side_r;
  logic signed [33:0] xo, yo;

  assign xo = cs_r[NC].flip ? -cx_r[NC] : cx_r[NC];
  assign yo = cs_r[NC].flip ? -cy_r[NC] : cy_r[NC];

  always_ff @(posedge clk) begin
    if (!rst_n) sc_v_r <= 1'b0;
    else if (en) sc_v_r <= cv_r[NC];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_c_r    <= xo[33:2];
      sc_s_r    <= yo[33:2];
      sc_side_r <= cs_r[NC];
    end
  end

  // Stage pm: the two cross products.
  logic               pm_v_r, pm_active_r, pm_last_r;
  logic signed [64:0] pm_a_r, pm_b_r;
  logic [65:0]        pm_dsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) pm_v_r <= 1'b0;
    else if (en) pm_v_r <= sc_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm_a_r      <= sc_side_r.dy * sc_c_r;
      pm_b_r      <= sc_side_r.dx * sc_s_r;
      pm_dsq_r    <= sc_side_r.dsq;
      pm_active_r <= sc_side_r.active;
      pm_last_r   <= sc_side_r.last;
    end
  end

  // Stage nm: numerator.
  logic               nm_v_r, nm_active_r, nm_last_r;
  logic signed [64:0] nm_n_r;
  logic [65:0]        nm_dsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) nm_v_r <= 1'b0;
    else if (en) nm_v_r <= pm_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_n_r      <= pm_a_r - pm_b_r;
      nm_dsq_r    <= pm_dsq_r;
      nm_active_r <= pm_active_r;
      nm_last_r   <= pm_last_r;
    end
  end

  // Stage ab: magnitude and sign of the numerator.
  logic        ab_v_r, ab_active_r, ab_last_r, ab_neg_r;
  logic [63:0] ab_an_r;
  logic [65:0] ab_dsq_r;
  logic signed [64:0] n_neg;

  assign n_neg = -nm_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ab_v_r <= 1'b0;
    else if (en) ab_v_r <= nm_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ab_an_r     <= nm_n_r[64] ? n_neg[63:0] : nm_n_r[63:0];
      ab_neg_r    <= nm_n_r[64];
      ab_dsq_r    <= nm_dsq_r;
      ab_active_r <= nm_active_r;
      ab_last_r   <= nm_last_r;
    end
  end

  // Stage pp: the 64 by 32 bit product as two halves.
  logic        pp_v_r, pp_active_r, pp_last_r, pp_neg_r;
  logic [63:0] pp_lo_r, pp_hi_r;
  logic [65:0] pp_dsq_r;
  logic [31:0] spd2;

  assign spd2 = {speed_ref_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) pp_v_r <= 1'b0;
    else if (en) pp_v_r <= ab_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo_r     <= ab_an_r[31:0] * spd2;
      pp_hi_r     <= ab_an_r[63:32] * spd2;
      pp_neg_r    <= ab_neg_r;
      pp_dsq_r    <= ab_dsq_r;
      pp_active_r <= ab_active_r;
      pp_last_r   <= ab_last_r;
    end
  end

  // Stage nu: dividend and divisor.
  logic        nu_v_r, nu_active_r, nu_last_r, nu_neg_r;
  logic [95:0] nu_num_r;
  logic [77:0] nu_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) nu_v_r <= 1'b0;
    else if (en) nu_v_r <= pp_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nu_num_r    <= {pp_hi_r, 32'd0} + {32'd0, pp_lo_r};
      nu_den_r    <= {pp_dsq_r, 12'd0};
      nu_neg_r    <= pp_neg_r;
      nu_active_r <= pp_active_r;
      nu_last_r   <= pp_last_r;
    end
  end

  // Divider: entry 0 holds the upper dividend as the partial remainder; a quotient of
  // 2^32 or more shows as that remainder already reaching the divisor.
  logic              dv_r  [0:ND];
  logic [77:0]       dr_r  [0:ND];
  logic [31:0]       dq_r  [0:ND];
  logic [31:0]       dn_r  [0:ND];
  logic [77:0]       dd_r  [0:ND];
  pps_pkg::div_tag_t dt_r  [0:ND];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (en) dv_r[0] <= nu_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr_r[0]        <= {14'd0, nu_num_r[95:32]};
      dq_r[0]        <= '0;
      dn_r[0]        <= nu_num_r[31:0];
      dd_r[0]        <= nu_den_r;
      dt_r[0].active <= nu_active_r;
      dt_r[0].neg    <= nu_neg_r;
      dt_r[0].ovf    <= {14'd0, nu_num_r[95:32]} >= nu_den_r;
      dt_r[0].last   <= nu_last_r;
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [78:0] rs, rd;
    assign rs = {dr_r[k], dn_r[k][31]};
    assign rd = rs - {1'b0, dd_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else if (en) dv_r[k+1] <= dv_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rs >= {1'b0, dd_r[k]}) begin
          dr_r[k+1] <= rd[77:0];
          dq_r[k+1] <= {dq_r[k][30:0], 1'b1};
        end else begin
          dr_r[k+1] <= rs[77:0];
          dq_r[k+1] <= {dq_r[k][30:0], 1'b0};
        end
        dn_r[k+1] <= {dn_r[k][30:0], 1'b0};
        dd_r[k+1] <= dd_r[k];
        dt_r[k+1] <= dt_r[k];
      end
    end
  end

  // Saturation, sign and the inactive case.
  logic        push;
  logic [31:0] lim, qc;
  logic        sat_raw;
  logic [30:0] f_speed;
  logic [31:0] f_rate;
  logic        f_active, f_sat, f_last;

  always_comb begin
    lim      = dt_r[ND].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat_raw  = dt_r[ND].ovf || (dq_r[ND] > lim);
    qc       = sat_raw ? lim : dq_r[ND];
    f_active = dt_r[ND].active;
    f_last   = dt_r[ND].last;
    f_sat    = f_active && sat_raw;
    f_speed  = f_active ? speed_ref_r : 31'd0;
    f_rate   = f_active ? (dt_r[ND].neg ? -qc : qc) : 32'd0;
  end

  // Two-entry output buffer.
  logic        out_v_r, skid_v_r, pop;
  logic [66:0] out_d_r, skid_d_r, f_beat;

  assign f_beat = {f_last, f_sat, f_active, 1'b0, f_rate, f_speed};
  assign en     = !(out_v_r && skid_v_r);
  assign push   = en && dv_r[ND];
  assign pop    = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= skid_v_r && push;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      out_d_r <= skid_v_r ? skid_d_r : f_beat;
      if (push) skid_d_r <= f_beat;
    end else if (push) begin
      skid_d_r <= f_beat;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r[63:0];
  assign out_tuser  = out_d_r[65:64];
  assign out_tlast  = out_d_r[66];

  // The tuser pair lives at bits 64 and 65 only through the packing above.
  a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 64'd0 && !out_tuser[1])
    else $error("inactive result carries a command");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held while output register empty");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_v_r && skid_v_r)
    else $error("pipeline halted with buffer room");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      out_tdata[62:31] == 32'h7FFF_FFFF || out_tdata[62:31] == 32'h8000_0000)
    else $error("saturated turn rate not at a limit");

endmodule

// File: tb/pps_steering_checker.sv
// Steering checker: follows the register writes, predicts each result and compares it.
`timescale 1ns / 100ps

module pps_steering_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         out_tlast,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           awaiting,
  output int           active_seen,
  output int           saturated_seen
);

  typedef struct {
    logic [30:0] speed_cmd;
    logic [31:0] turn_rate_cmd;
    logic        steer_active;
    logic        rate_saturated;
    logic        last_agent_out;
  } steer_cmd_t;

  localparam longint ROT_ANGLE_PI   = 64'sd3373259426;
  localparam longint ROT_ANGLE_HALF = 64'sd1686629713;
  localparam longint ROT_START_X    = 64'sd652032874;

  localparam longint ARCTAN_Q30 [20] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF
  };

  logic [30:0] speed_ref_q;
  logic [30:0] near_thr_q;
  steer_cmd_t  pending_cmds[$];

  function automatic steer_cmd_t predict_steering(input logic [143:0] beat, input logic last);
    steer_cmd_t   cmd;
    longint       ax, ay, gx, gy, hd, dx, dy;
    longint       ang, rx, ry, nx, cosv, sinv, numer;
    logic [127:0] adx, ady, dist_sq, thr_sq, prod, den, quot, lim;
    logic         flip, neg;
    ax = longint'($signed(beat[31:0]));
    ay = longint'($signed(beat[63:32]));
    hd = longint'($signed(beat[79:64]));
    gx = longint'($signed(beat[111:80]));
    gy = longint'($signed(beat[143:112]));
    dx = gx - ax;
    dy = gy - ay;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    dist_sq = adx * adx + ady * ady;
    thr_sq = 128'(near_thr_q) * 128'(near_thr_q);
    cmd = '{default: '0};
    cmd.last_agent_out = last;
    cmd.steer_active = dist_sq > thr_sq;
    if (cmd.steer_active) begin
      // Fold the heading into the rotator's range, then undo the half turn at the end.
      ang = hd * 131072;
      flip = 1'b0;
      if (ang > ROT_ANGLE_HALF) begin
        ang -= ROT_ANGLE_PI;
        flip = 1'b1;
      end else if (ang < -ROT_ANGLE_HALF) begin
        ang += ROT_ANGLE_PI;
        flip = 1'b1;
      end
      rx = ROT_START_X;
      ry = 0;
      for (int i = 0; i < 20; i++) begin
        if (ang >= 0) begin
          nx = rx - (ry >>> i);
          ry = ry + (rx >>> i);
          ang -= ARCTAN_Q30[i];
        end else begin
          nx = rx + (ry >>> i);
          ry = ry - (rx >>> i);
          ang += ARCTAN_Q30[i];
        end
        rx = nx;
      end
      if (flip) begin
        rx = -rx;
        ry = -ry;
      end
      cosv = rx >>> 2;
      sinv = ry >>> 2;
      numer = dy * cosv - dx * sinv;
      neg = numer < 0;
      prod = 128'(neg ? -numer : numer) * (128'(speed_ref_q) * 2);
      den = dist_sq << 12;
      quot = prod / den;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (quot > lim) begin
        quot = lim;
        cmd.rate_saturated = 1'b1;
      end
      cmd.turn_rate_cmd = neg ? (32'd0 - quot[31:0]) : quot[31:0];
      cmd.speed_cmd = speed_ref_q;
    end
    return cmd;
  endfunction

  assign awaiting = pending_cmds.size();

  always @(posedge clk) begin
    steer_cmd_t want;
    int         errs;
    errs = 0;
    if (!rst_n) begin
      speed_ref_q <= 31'd65536;
      near_thr_q <= 31'd6554;
      pending_cmds.delete();
      fail_count <= 0;
      active_seen <= 0;
      saturated_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pps_pkg::CFG_SPEED_REF) speed_ref_q <= cfg_data[30:0];
        else if (cfg_index == pps_pkg::CFG_NEAR_THR) near_thr_q <= cfg_data[30:0];
      end
      if (in_tvalid && in_tready) pending_cmds.push_back(predict_steering(in_tdata, in_tlast));
      if (out_tvalid && out_tready) begin
        if (pending_cmds.size() == 0) begin
          $error("result beat with no vehicle outstanding");
          errs++;
        end else begin
          want = pending_cmds.pop_front();
          if (want.steer_active) active_seen <= active_seen + 1;
          if (want.rate_saturated) saturated_seen <= saturated_seen + 1;
          if (out_tdata[30:0] !== want.speed_cmd) begin
            $error("speed_cmd: expected %0d, got %0d", want.speed_cmd, out_tdata[30:0]);
            errs++;
          end
          if (out_tdata[62:31] !== want.turn_rate_cmd) begin
            $error("turn_rate_cmd: expected %0d, got %0d", $signed(want.turn_rate_cmd),
                   $signed(out_tdata[62:31]));
            errs++;
          end
          if (out_tuser[0] !== want.steer_active) begin
            $error("steer_active: expected %0b, got %0b", want.steer_active, out_tuser[0]);
            errs++;
          end
          if (out_tuser[1] !== want.rate_saturated) begin
            $error("rate_saturated: expected %0b, got %0b", want.rate_saturated,
                   out_tuser[1]);
            errs++;
          end
          if (out_tlast !== want.last_agent_out) begin
            $error("last_agent_out: expected %0b, got %0b", want.last_agent_out, out_tlast);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

// File: tb/tb_pure_pursuit_steering_unit.sv
// Testbench top: drives vehicles and register writes through several settings and gives the verdict.
`timescale 1ns / 100ps

module tb_pure_pursuit_steering_unit;

  localparam logic [7:0] CFG_NO_SUCH_REG = 8'd2;
  localparam int         PIPE_LATENCY    = 64;
  localparam int         CYCLE_LIMIT     = 400000;

  typedef struct {
    logic [31:0] agent_x;
    logic [31:0] agent_y;
    logic [15:0] heading;
    logic [31:0] goal_x;
    logic [31:0] goal_y;
    logic        last_agent;
  } vehicle_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_index;
  logic [31:0]  cfg_data;

  int fail_count, awaiting, active_seen, saturated_seen;
  int send_idle_pct, recv_stall_pct;
  int vehicles_sent, cycle_count;
  int unsigned thr_now;

  pure_pursuit_steering_unit i_dut (.*);

  pps_steering_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_vehicle(input vehicle_t v);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {v.goal_y, v.goal_x, v.heading, v.agent_y, v.agent_x};
    in_tlast <= v.last_agent;
    do @(posedge clk); while (!in_tready);
    vehicles_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (awaiting != 0) @(posedge clk);
    // Results trail the last beat by the pipeline depth; let it settle.
    repeat (PIPE_LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == pps_pkg::CFG_NEAR_THR) thr_now = {1'b0, val[30:0]};
  endtask

  function automatic vehicle_t make_vehicle(input logic [31:0] ax, input logic [31:0] ay,
                                            input logic [15:0] hd, input logic [31:0] gx,
                                            input logic [31:0] gy, input logic last);
    vehicle_t v;
    v = '{ax, ay, hd, gx, gy, last};
    return v;
  endfunction

  function automatic vehicle_t random_vehicle();
    vehicle_t v;
    int       kind;
    int       span;
    v.agent_x = $urandom;
    v.agent_y = $urandom;
    v.heading = 16'($urandom);
    v.last_agent = ($urandom_range(0, 7) == 0);
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      // Target at a random scale from the vehicle.
      span = $urandom_range(0, 31);
      v.goal_x = v.agent_x + ($signed($urandom) >>> span);
      v.goal_y = v.agent_y + ($signed($urandom) >>> span);
    end else if (kind <= 6) begin
      // Target close to the threshold circle.
      v.goal_x = v.agent_x + thr_now - $urandom_range(0, 3);
      v.goal_y = v.agent_y + $urandom_range(0, 3) - 1;
    end else if (kind == 7) begin
      v.goal_x = v.agent_x;
      v.goal_y = v.agent_y;
    end else begin
      v.goal_x = $urandom;
      v.goal_y = $urandom;
    end
    return v;
  endfunction

  task automatic random_run(input int count, input int idle_mode);
    for (int i = 0; i < count; i++) begin
      // Stretches with no idling at all, in every phase.
      if (i % 60 < 12) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct = (idle_mode == 1) ? 47 : (idle_mode == 3) ? 37 : 0;
        recv_stall_pct = (idle_mode == 2) ? 47 : (idle_mode == 3) ? 37 : 0;
      end
      send_vehicle(random_vehicle());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = pps_pkg::CFG_SPEED_REF;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    vehicles_sent = 0;
    cycle_count = 0;
    thr_now = 6554;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed vehicles under the reset register values.
    send_vehicle(make_vehicle(32'h0, 32'h0, 16'h0, 32'h0, 32'h0, 1'b0));
    send_vehicle(make_vehicle(32'h0, 32'h0, 16'h0, 32'd6554, 32'h0, 1'b1));
    send_vehicle(make_vehicle(32'h0, 32'h0, 16'h0, 32'd6555, 32'h0, 1'b0));
    send_vehicle(make_vehicle(32'h8000_0000, 32'h8000_0000, 16'h8000,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    send_vehicle(make_vehicle(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF,
                              32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    send_vehicle(make_vehicle(32'h0, 32'h0, 16'd12868, 32'h0, 32'h10000, 1'b0));
    send_vehicle(make_vehicle(32'h0, 32'h0, 16'd12869, 32'h10000, 32'h0, 1'b0));
    send_vehicle(make_vehicle(32'h0, 32'h0, -16'sd12869, 32'hFFFF0000, 32'h0, 1'b0));
    send_vehicle(make_vehicle(32'h0, 32'h0, -16'sd25736, 32'h0, 32'h8000, 1'b0));
    send_vehicle(make_vehicle(32'hFFFF_FFFF, 32'h0, 16'd25736, 32'h0, 32'h2000, 1'b1));
    send_vehicle(make_vehicle(32'h0, 32'h0, 16'd4000, 32'h0, 32'hFFFF_E000, 1'b0));
    drain();

    // Saturation: full speed on a target just past a zero threshold.
    write_reg(pps_pkg::CFG_SPEED_REF, 32'h7FFF_FFFF);
    write_reg(pps_pkg::CFG_NEAR_THR, 32'h0);
    write_reg(CFG_NO_SUCH_REG, 32'h1234_5678);
    send_vehicle(make_vehicle(32'h0, 32'h0, 16'h0, 32'h0, 32'h1, 1'b0));
    send_vehicle(make_vehicle(32'h0, 32'h0, 16'h0, 32'h0, 32'hFFFF_FFFF, 1'b1));
    send_vehicle(make_vehicle(32'h0, 32'h0, 16'd4000, 32'h1, 32'h1, 1'b0));
    send_vehicle(make_vehicle(32'h5, 32'h5, 16'h0, 32'h5, 32'h5, 1'b0));
    send_vehicle(make_vehicle(32'h0, 32'h0, 16'h0, 32'h1, 32'h0, 1'b0));
    random_run(200, 0);
    drain();

    // Zero speed, register bits above the field set.
    write_reg(pps_pkg::CFG_SPEED_REF, 32'h8000_0000);
    write_reg(pps_pkg::CFG_NEAR_THR, 32'h8000_0400);
    random_run(200, 1);
    drain();

    write_reg(pps_pkg::CFG_SPEED_REF, 32'h0003_4000);
    write_reg(pps_pkg::CFG_NEAR_THR, 32'h7FFF_FFFF);
    random_run(100, 2);
    // Hold off until the pipeline has delivered everything.
    drain();
    random_run(120, 2);
    drain();

    write_reg(pps_pkg::CFG_SPEED_REF, 32'd65536);
    write_reg(pps_pkg::CFG_NEAR_THR, 32'd6554);
    random_run(240, 3);
    drain();

    write_reg(pps_pkg::CFG_SPEED_REF, $urandom);
    write_reg(pps_pkg::CFG_NEAR_THR, $urandom >> $urandom_range(1, 31));
    random_run(220, 0);
    drain();

    $display("Run covered %0d vehicles under six register settings and four idling phases.",
             vehicles_sent);
    $display("Steering was active for %0d of them, with the turn rate clipped %0d times.",
             active_seen, saturated_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
